// ===== sv/oblate_body_quadrupole_accel_assert.svh =====
// assertion macros for the oblate body quadrupole pipeline
// expects clk and rst_n in the scope of the module that uses them
`ifndef OBLATE_BODY_QUADRUPOLE_ACCEL_ASSERT_SVH
`define OBLATE_BODY_QUADRUPOLE_ACCEL_ASSERT_SVH

// consequent checked in the same cycle
`define OBQA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obqa: check failed");

// consequent checked in the cycle after the antecedent
`define OBQA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obqa: check failed");

`endif

// ===== sv/obqa_pkg.sv =====
// types and constants for the oblate body quadrupole pipeline
// no dependencies
package obqa_pkg;

    typedef struct packed {
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] body_z;
        logic [31:0]        body_mass;
        logic               is_primary;
        logic               last_body;
    } body_word_t;

    typedef struct packed {
        logic signed [47:0] accel_x;
        logic signed [47:0] accel_y;
        logic signed [47:0] accel_z;
        logic signed [47:0] react_x;
        logic signed [47:0] react_y;
        logic signed [47:0] react_z;
        logic               last_out;
    } result_word_t;

    typedef enum logic [3:0] {
        CFG_PRIMARY_X  = 4'd0,
        CFG_PRIMARY_Y  = 4'd1,
        CFG_PRIMARY_Z  = 4'd2,
        CFG_QUAD_COEF  = 4'd3,
        CFG_POLE_HX    = 4'd4,
        CFG_POLE_HY    = 4'd5,
        CFG_POLE_HZ    = 4'd6,
        CFG_MASS_RECIP = 4'd7
    } cfg_index_t;

    localparam logic [17:0] POLE_HZ_RESET = 18'd65536;
    localparam logic [47:0] SAT_POS_MAG   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG_MAG   = 48'h8000_0000_0000;
    // d_k times one in Q.16: 1 for x and y, 3 for z
    localparam logic [23:0] F_OFF_XY      = 24'd65536;
    localparam logic [23:0] F_OFF_Z       = 24'd196608;

endpackage

// ===== sv/obqa_mul.sv =====
// two-stage unsigned multiplier built from 32x32 partial products
// no dependencies
module obqa_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    localparam int NA   = (WA + 31) / 32;
    localparam int NB   = (WB + 31) / 32;
    localparam int WACC = 32 * (NA + NB);

    typedef logic [NA*32-1:0] ax_t;
    typedef logic [NB*32-1:0] bx_t;
    typedef logic [WACC-1:0]  acc_t;

    ax_t                     ax;
    bx_t                     bx;
    logic [NA*NB-1:0][63:0]  pp_reg;
    acc_t                    acc;
    logic [WA+WB-1:0]        p_reg;

    assign ax = ax_t'(a);
    assign bx = bx_t'(b);

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= ax[i*32 +: 32] * bx[j*32 +: 32];
                end
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (acc_t'(pp_reg[i*NB+j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc[WA+WB-1:0];
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/oblate_body_quadrupole_accel.sv =====
// top level of the oblate body quadrupole acceleration pipeline
// uses obqa_pkg, obqa_mul and oblate_body_quadrupole_accel_assert.svh

// Takes one body word per cycle while the pipeline is not held and returns one result
// word per body, in order. The pipeline is built around the bit-serial stages: 33
// for the square root of |r|^2, 20 for the cos^2 quotient and 48 for the
// acceleration quotient, with the multiplier stages around them. The whole
// pipeline holds while a finished result word is not taken. Configuration writes
// take effect at once and are meant to be made while no body is in flight.
`include "oblate_body_quadrupole_accel_assert.svh"

module oblate_body_quadrupole_accel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  obqa_pkg::body_word_t item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output obqa_pkg::result_word_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [47:0]          cfg_data
);
    import obqa_pkg::*;

    localparam int NST = 96;

    logic               stage_en;
    logic [NST-1:0]     vld_reg;

    logic [31:0]        prim_x_reg, prim_y_reg, prim_z_reg;
    logic [47:0]        coef_reg;
    logic [17:0]        pole_hx_reg, pole_hy_reg, pole_hz_reg;
    logic [31:0]        recip_reg;

    logic [2:0][31:0]   prim_pos;
    logic [2:0][17:0]   pole;
    logic [2:0][31:0]   body_pos;

    // stages 1 to 3
    logic [2:0][32:0]   r_next;
    logic [2:0][32:0]   r_s1_reg;
    logic [31:0]        mass_s1_reg;
    logic [1:0]         flg_s1_reg;
    logic [2:0][65:0]   sq_s2_reg;
    logic [2:0][50:0]   dp_s2_reg;
    logic [2:0][32:0]   rmag_s2_reg;
    logic [65:0]        s_s3_reg;
    logic [50:0]        dmag_s3_reg;
    logic signed [52:0] dsum_next;

    // square root
    logic [65:0]        sqx_reg [33];
    logic [32:0]        sqq_reg [33];
    logic [4:0][32:0]   rho_d_reg;
    logic [65:0]        rho2_s37_reg;
    logic [98:0]        rho3;
    logic [131:0]       rho4;
    logic [164:0]       rho5;
    logic [164:0]       den_s44_reg;

    // cos^2 quotient
    logic [101:0]       dsq;
    logic [1:0][65:0]   s_d_reg;
    logic [81:0]        cp_reg [20];
    logic [19:0]        cq_reg [20];
    logic [65:0]        cs_reg [20];
    logic [19:0]        cn_reg [20];
    logic [19:0]        cos2;

    // per-axis terms
    logic [23:0][2:0]   rneg_d_reg;
    logic [21:0][98:0]  rmag_d_reg;
    logic [2:0][21:0]   fmag_s26_reg;
    logic [2:0]         neg_s26_reg;
    logic [2:0][80:0]   cr;
    logic [2:0][102:0]  num;
    logic [15:0][308:0] num_d_reg;
    logic [68:0][2:0]   neg_d_reg;

    // acceleration quotient
    logic [165:0]       bp0_reg [3];
    logic [2:0]         ovf0_reg;
    logic [164:0]       den45_reg;
    logic [165:0]       bp_reg [3][47];
    logic [46:0]        bq_reg [3][47];
    logic               bovf_reg [3][47];
    logic [164:0]       bden_reg [47];

    // reaction
    logic [89:0][31:0]  mass_d_reg;
    logic [63:0]        mm;
    logic [2:0][47:0]   amag_s93_reg;
    logic [2:0][47:0]   accel_s93_reg;
    logic [2:0][111:0]  pr;
    logic [1:0][143:0]  accel_d_reg;
    logic [93:0][1:0]   flg_d_reg;
    logic [2:0][47:0]   react_next;
    result_word_t       result_reg;

    assign stage_en     = !vld_reg[NST-1] || result_ready;
    assign item_ready   = stage_en;
    assign result_valid = vld_reg[NST-1];
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (stage_en)
        begin
            vld_reg <= {vld_reg[NST-2:0], item_valid};
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_x_reg  <= '0;
            prim_y_reg  <= '0;
            prim_z_reg  <= '0;
            coef_reg    <= '0;
            pole_hx_reg <= '0;
            pole_hy_reg <= '0;
            pole_hz_reg <= POLE_HZ_RESET;
            recip_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRIMARY_X:  prim_x_reg  <= cfg_data[31:0];
                CFG_PRIMARY_Y:  prim_y_reg  <= cfg_data[31:0];
                CFG_PRIMARY_Z:  prim_z_reg  <= cfg_data[31:0];
                CFG_QUAD_COEF:  coef_reg    <= cfg_data;
                CFG_POLE_HX:    pole_hx_reg <= cfg_data[17:0];
                CFG_POLE_HY:    pole_hy_reg <= cfg_data[17:0];
                CFG_POLE_HZ:    pole_hz_reg <= cfg_data[17:0];
                CFG_MASS_RECIP: recip_reg   <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    assign prim_pos = {prim_z_reg, prim_y_reg, prim_x_reg};
    assign pole     = {pole_hz_reg, pole_hy_reg, pole_hx_reg};
    assign body_pos = {item.body_z, item.body_y, item.body_x};

    // offset, squares, dot product
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            r_next[k] = {body_pos[k][31], body_pos[k]} - {prim_pos[k][31], prim_pos[k]};
        end
        dsum_next = 53'(signed'(dp_s2_reg[0])) + 53'(signed'(dp_s2_reg[1]))
                  + 53'(signed'(dp_s2_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            r_s1_reg    <= r_next;
            mass_s1_reg <= item.body_mass;
            flg_s1_reg  <= {item.is_primary, item.last_body};
            for (int k = 0; k < 3; k++)
            begin
                sq_s2_reg[k]   <= 66'($signed(r_s1_reg[k]) * $signed(r_s1_reg[k]));
                dp_s2_reg[k]   <= 51'($signed(r_s1_reg[k]) * $signed(pole[k]));
                rmag_s2_reg[k] <= r_s1_reg[k][32] ? 33'(-r_s1_reg[k]) : r_s1_reg[k];
            end
            s_s3_reg    <= sq_s2_reg[0] + sq_s2_reg[1] + sq_s2_reg[2];
            dmag_s3_reg <= dsum_next[52] ? 51'(-dsum_next) : 51'(dsum_next);
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < 33; j++)
    begin : g_sqrt
        localparam int B = 32 - j;
        logic [65:0] x_in;
        logic [32:0] q_in;
        logic [67:0] trial;
        logic        take;

        if (j == 0)
        begin : g_first
            assign x_in = s_s3_reg;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign x_in = sqx_reg[j-1];
            assign q_in = sqq_reg[j-1];
        end

        assign trial = (68'(q_in) << (B + 1)) | (68'(1) << (2 * B));
        assign take  = {2'b00, x_in} >= trial;

        always_ff @(posedge clk)
        begin
            if (stage_en)
            begin
                sqx_reg[j] <= take ? 66'({2'b00, x_in} - trial) : x_in;
                sqq_reg[j] <= take ? (q_in | (33'(1) << B)) : q_in;
            end
        end
    end

    // rho^5 + 0.5
    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            rho_d_reg    <= {rho_d_reg[3:0], sqq_reg[32]};
            rho2_s37_reg <= sqq_reg[32] * sqq_reg[32];
            den_s44_reg  <= rho5 + (165'(1) << 79);
        end
    end

    obqa_mul #(.WA(66), .WB(33)) u_rho3 (
        .clk(clk), .en(stage_en), .a(rho2_s37_reg), .b(rho_d_reg[0]), .p(rho3)
    );
    obqa_mul #(.WA(99), .WB(33)) u_rho4 (
        .clk(clk), .en(stage_en), .a(rho3), .b(rho_d_reg[2]), .p(rho4)
    );
    obqa_mul #(.WA(132), .WB(33)) u_rho5 (
        .clk(clk), .en(stage_en), .a(rho4), .b(rho_d_reg[4]), .p(rho5)
    );

    // cos^2 = floor(D^2 / (S * 2^16)), below 2^20
    obqa_mul #(.WA(51), .WB(51)) u_dsq (
        .clk(clk), .en(stage_en), .a(dmag_s3_reg), .b(dmag_s3_reg), .p(dsq)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            s_d_reg <= {s_d_reg[0], s_s3_reg};
        end
    end

    for (genvar j = 0; j < 20; j++)
    begin : g_cdiv
        logic [81:0] p_in;
        logic [19:0] q_in;
        logic [65:0] s_in;
        logic [19:0] n_in;
        logic [82:0] shifted;
        logic [82:0] dv;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign p_in = dsq[101:20];
            assign q_in = '0;
            assign s_in = s_d_reg[1];
            assign n_in = dsq[19:0];
        end
        else
        begin : g_rest
            assign p_in = cp_reg[j-1];
            assign q_in = cq_reg[j-1];
            assign s_in = cs_reg[j-1];
            assign n_in = cn_reg[j-1];
        end

        assign shifted = {p_in, n_in[19]};
        assign dv      = {1'b0, s_in, 16'h0000};
        assign ge      = shifted >= dv;

        always_ff @(posedge clk)
        begin
            if (stage_en)
            begin
                cp_reg[j] <= ge ? 82'(shifted - dv) : shifted[81:0];
                cq_reg[j] <= {q_in[18:0], ge};
                cs_reg[j] <= s_in;
                cn_reg[j] <= {n_in[18:0], 1'b0};
            end
        end
    end

    // zero offset gives cos^2 of zero
    assign cos2 = (cs_reg[19] == '0) ? '0 : cq_reg[19];

    // F_k = 5 cos^2 - d_k, then coeff * |r_k| * |F_k|
    always_ff @(posedge clk)
    begin
        logic [22:0]        five_c;
        logic signed [23:0] f;
        if (stage_en)
        begin
            rneg_d_reg <= {rneg_d_reg[22:0],
                           {r_s1_reg[2][32], r_s1_reg[1][32], r_s1_reg[0][32]}};
            rmag_d_reg <= {rmag_d_reg[20:0], {rmag_s2_reg[2], rmag_s2_reg[1], rmag_s2_reg[0]}};
            five_c = 23'({cos2, 2'b00}) + 23'(cos2);
            for (int k = 0; k < 3; k++)
            begin
                f = $signed({1'b0, five_c}) - $signed((k == 2) ? F_OFF_Z : F_OFF_XY);
                fmag_s26_reg[k] <= f[23] ? 22'(-f) : 22'(f);
                neg_s26_reg[k]  <= rneg_d_reg[23][k] ^ f[23];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_num
        obqa_mul #(.WA(48), .WB(33)) u_cr (
            .clk(clk), .en(stage_en), .a(coef_reg),
            .b(rmag_d_reg[21][k*33 +: 33]), .p(cr[k])
        );
        obqa_mul #(.WA(81), .WB(22)) u_num (
            .clk(clk), .en(stage_en), .a(cr[k]), .b(fmag_s26_reg[k]), .p(num[k])
        );
    end

    // acceleration quotient: overflow check, then 47 quotient bits
    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            num_d_reg <= {num_d_reg[14:0], {num[2], num[1], num[0]}};
            neg_d_reg <= {neg_d_reg[67:0], neg_s26_reg};
            den45_reg <= den_s44_reg;
            for (int k = 0; k < 3; k++)
            begin
                bp0_reg[k]  <= {62'h0, num_d_reg[15][k*103 +: 103], 1'b0};
                ovf0_reg[k] <= {62'h0, num_d_reg[15][k*103 +: 103], 1'b0}
                               >= {1'b0, den_s44_reg};
            end
        end
    end

    for (genvar j = 0; j < 47; j++)
    begin : g_adiv
        logic [164:0] den_in;

        if (j == 0)
        begin : g_first
            assign den_in = den45_reg;
        end
        else
        begin : g_rest
            assign den_in = bden_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (stage_en)
            begin
                bden_reg[j] <= den_in;
            end
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            logic [165:0] p_in;
            logic [46:0]  q_in;
            logic         ovf_in;
            logic [165:0] shifted;
            logic         ge;

            if (j == 0)
            begin : g_first
                assign p_in   = bp0_reg[k];
                assign q_in   = '0;
                assign ovf_in = ovf0_reg[k];
            end
            else
            begin : g_rest
                assign p_in   = bp_reg[k][j-1];
                assign q_in   = bq_reg[k][j-1];
                assign ovf_in = bovf_reg[k][j-1];
            end

            assign shifted = {p_in[164:0], 1'b0};
            assign ge      = shifted >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (stage_en)
                begin
                    bp_reg[k][j]   <= ge ? (shifted - {1'b0, den_in}) : shifted;
                    bq_reg[k][j]   <= {q_in[45:0], ge};
                    bovf_reg[k][j] <= ovf_in;
                end
            end
        end
    end

    // saturate acceleration, form reaction
    always_ff @(posedge clk)
    begin
        logic [47:0] amag;
        if (stage_en)
        begin
            mass_d_reg  <= {mass_d_reg[88:0], mass_s1_reg};
            flg_d_reg   <= {flg_d_reg[92:0], flg_s1_reg};
            accel_d_reg <= {accel_d_reg[0],
                            {accel_s93_reg[2], accel_s93_reg[1], accel_s93_reg[0]}};
            for (int k = 0; k < 3; k++)
            begin
                if (bovf_reg[k][46])
                begin
                    amag = neg_d_reg[65][k] ? SAT_NEG_MAG : SAT_POS_MAG;
                end
                else
                begin
                    amag = {1'b0, bq_reg[k][46]};
                end
                amag_s93_reg[k]  <= amag;
                accel_s93_reg[k] <= neg_d_reg[65][k] ? 48'(-amag) : amag;
            end
        end
    end

    obqa_mul #(.WA(32), .WB(32)) u_mm (
        .clk(clk), .en(stage_en), .a(mass_d_reg[89]), .b(recip_reg), .p(mm)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_react
        logic [63:0] rm;
        logic [47:0] lim;
        logic [47:0] rv;

        obqa_mul #(.WA(48), .WB(64)) u_pr (
            .clk(clk), .en(stage_en), .a(amag_s93_reg[k]), .b(mm), .p(pr[k])
        );

        // reaction opposes the acceleration
        assign rm  = pr[k][111:48];
        assign lim = neg_d_reg[68][k] ? SAT_POS_MAG : SAT_NEG_MAG;
        assign rv  = (rm > 64'(lim)) ? lim : rm[47:0];
        assign react_next[k] = neg_d_reg[68][k] ? rv : 48'(-rv);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            result_reg.last_out <= flg_d_reg[93][0];
            if (flg_d_reg[93][1])
            begin
                result_reg.accel_x <= '0;
                result_reg.accel_y <= '0;
                result_reg.accel_z <= '0;
                result_reg.react_x <= '0;
                result_reg.react_y <= '0;
                result_reg.react_z <= '0;
            end
            else
            begin
                result_reg.accel_x <= accel_d_reg[1][47:0];
                result_reg.accel_y <= accel_d_reg[1][95:48];
                result_reg.accel_z <= accel_d_reg[1][143:96];
                result_reg.react_x <= react_next[0];
                result_reg.react_y <= react_next[1];
                result_reg.react_z <= react_next[2];
            end
        end
    end

    `OBQA_ASSERT_NXT(a_primary_zero, stage_en && vld_reg[NST-2] && flg_d_reg[93][1], result.accel_x == '0 && result.react_z == '0)
    `OBQA_ASSERT_IMP(a_zero_accel_no_react, result_valid && result.accel_x == '0, result.react_x == '0)
    `OBQA_ASSERT_IMP(a_react_opposes, result_valid && result.accel_y != '0 && result.react_y != '0, result.accel_y[47] != result.react_y[47])

endmodule
